FILE: rtl/core/well_pkg.sv
// Shared types, constants and ring-index helper for the WELL19937a generator.
// Used by every module under rtl/core; depends on nothing else.
package well_pkg;

  // Ring geometry
  localparam int unsigned RingDepth = 624;
  localparam int unsigned RingAw    = 10;
  localparam int unsigned WordW     = 32;

  // Recurrence tap offsets, ahead of the position
  localparam int unsigned OfsA = 70;
  localparam int unsigned OfsB = 179;
  localparam int unsigned OfsC = 449;

  // Word masks and tempering constants
  localparam logic [WordW-1:0] TopBit   = 32'h8000_0000;
  localparam logic [WordW-1:0] LowBits  = 32'h7fff_ffff;
  localparam logic [WordW-1:0] TemperB  = 32'he46e_1700;
  localparam logic [WordW-1:0] TemperC  = 32'h9b86_8000;

  // Stream payload widths
  localparam int unsigned TdataInW  = 48;

  // Request kinds carried on tuser
  localparam logic KindLoad = 1'b0;
  localparam logic KindGen  = 1'b1;

  typedef logic [RingAw-1:0] ring_addr_t;
  typedef logic [WordW-1:0]  word_t;

  // One request to a ring memory port
  typedef struct packed {
    logic       en;
    logic       we;
    ring_addr_t addr;
    word_t      wdata;
  } ram_req_t;

  // Words produced by one recurrence step
  typedef struct packed {
    word_t store_word;  // written back at the old position
    word_t new_word;    // written at the new position
    word_t out_word;    // emitted word, tempered if enabled
  } mix_res_t;

  // Step forward around the ring; ofs must lie below RingDepth
  function automatic ring_addr_t ring_fwd(ring_addr_t pos, ring_addr_t ofs);
    logic [RingAw:0] sum;
    sum = {1'b0, pos} + {1'b0, ofs};
    if (sum >= (RingAw + 1)'(RingDepth)) begin
      sum = sum - (RingAw + 1)'(RingDepth);
    end
    return sum[RingAw-1:0];
  endfunction

endpackage

FILE: rtl/core/well_ring_ram.sv
// Dual-port synchronous state ring, registered read on each port.
// Depends on well_pkg for the depth, word width and port request type.
module well_ring_ram
  import well_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t port_a_i,
  input  ram_req_t port_b_i,
  output word_t    rdata_a_o,
  output word_t    rdata_b_o
);

  word_t mem [RingDepth];
  word_t rdata_a_q;
  word_t rdata_b_q;

  // Serve both ports: write or registered read; read data holds while idle.
  // The two ports never write the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    if (port_a_i.en) begin
      if (port_a_i.we) begin
        mem[port_a_i.addr] <= port_a_i.wdata;
      end else begin
        rdata_a_q <= mem[port_a_i.addr];
      end
    end
    if (port_b_i.en) begin
      if (port_b_i.we) begin
        mem[port_b_i.addr] <= port_b_i.wdata;
      end else begin
        rdata_b_q <= mem[port_b_i.addr];
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/core/well_mix.sv
// WELL19937a recurrence step and output tempering for one generated word.
// Depends on well_pkg for word types, masks and tempering constants.
module well_mix
  import well_pkg::*;
(
  input  word_t    v0_i,
  input  word_t    va_i,
  input  word_t    vb_i,
  input  word_t    vc_i,
  input  word_t    back1_i,
  input  word_t    back2_i,
  input  logic     temper_en_i,
  output mix_res_t res_o
);

  word_t z0;
  word_t z1;
  word_t z2;
  word_t nv1;
  word_t nv0;
  word_t t1;
  word_t t2;

  // Form the recurrence terms
  always_comb begin
    z0  = (back1_i & TopBit) | (back2_i & LowBits);
    z1  = v0_i ^ (v0_i << 25) ^ va_i ^ (va_i >> 27);
    z2  = (vb_i >> 9) ^ vc_i ^ (vc_i >> 1);
    nv1 = z1 ^ z2;
    nv0 = z0 ^ (z1 << 9) ^ (z2 << 21) ^ (nv1 >> 21);
  end

  // Temper the emitted copy only
  always_comb begin
    t1 = nv0 ^ ((nv0 << 7) & TemperB);
    t2 = t1 ^ ((t1 << 15) & TemperC);
  end

  assign res_o.store_word = nv1;
  assign res_o.new_word   = nv0;
  assign res_o.out_word   = temper_en_i ? t2 : nv0;

endmodule

FILE: rtl/core/well19937_random_generator.sv
// Top level of the WELL19937a generator: stream ports, sequencer, output register.
// Depends on well_pkg, well_ring_ram and well_mix.
//
//  channel  | direction | payload (lowest bit first)
//  ---------+-----------+-----------------------------------------------
//  s_axis   | in        | tuser: kind; tdata: load_index[9:0], load_value[41:10]
//  m_axis   | out       | tdata: random_word[31:0]
//  cfg      | in        | cfg_wdata_i: temper_enable
//
// A load request is written to the ring as it is accepted. For a generate request the six
// ring reads share the two ports of the ring memory in StIdle, StRd1 and StRd2, and the
// two write-backs follow in StWr. One request is in flight at a time.
// The result waits in an output register; a full, unread output register holds
// the write-back cycle. Reset clears the position and the temper enable; the
// ring is not cleared and must be loaded before the first generate.
module well19937_random_generator
  import well_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Requests
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [TdataInW-1:0] s_axis_tdata_i,   // load_index[9:0], load_value[41:10]
  input  logic                s_axis_tuser_i,   // kind[0]
  // Results
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [WordW-1:0]    m_axis_tdata_o,   // random_word[31:0]
  // Configuration
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StRd1,
    StRd2,
    StWr
  } gen_state_e;

  gen_state_e state_q, state_d;
  ring_addr_t pos_q, pos_d;
  logic       temper_q, temper_d;
  logic       m_valid_q, m_valid_d;
  word_t      m_data_q, m_data_d;
  word_t      v0_q, v0_d;
  word_t      va_q, va_d;
  word_t      vb_q, vb_d;
  word_t      vc_q, vc_d;

  ram_req_t   port_a;
  ram_req_t   port_b;
  word_t      rdata_a;
  word_t      rdata_b;
  mix_res_t   mix_res;

  logic       in_accept;
  logic       out_free;
  ring_addr_t load_idx;
  word_t      load_val;
  ring_addr_t back1;
  ring_addr_t back2;

  assign load_idx  = s_axis_tdata_i[RingAw-1:0];
  assign load_val  = s_axis_tdata_i[RingAw +: WordW];
  assign back1     = ring_fwd(pos_q, ring_addr_t'(RingDepth - 1));
  assign back2     = ring_fwd(pos_q, ring_addr_t'(RingDepth - 2));

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  well_ring_ram u_ring (
    .clk_i     (clk_i),
    .port_a_i  (port_a),
    .port_b_i  (port_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  well_mix u_mix (
    .v0_i        (v0_q),
    .va_i        (va_q),
    .vb_i        (vb_q),
    .vc_i        (vc_q),
    .back1_i     (rdata_a),
    .back2_i     (rdata_b),
    .temper_en_i (temper_q),
    .res_o       (mix_res)
  );

  // Sequence ring accesses and next-state values
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    temper_d  = cfg_we_i ? cfg_wdata_i : temper_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    m_data_d  = m_data_q;
    v0_d      = v0_q;
    va_d      = va_q;
    vb_d      = vb_q;
    vc_d      = vc_q;
    port_a    = '0;
    port_b    = '0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (s_axis_tuser_i == KindLoad) begin
            // Drop loads beyond the ring
            port_a.en    = (load_idx < ring_addr_t'(RingDepth));
            port_a.we    = 1'b1;
            port_a.addr  = load_idx;
            port_a.wdata = load_val;
          end else begin
            port_a.en   = 1'b1;
            port_a.addr = pos_q;
            port_b.en   = 1'b1;
            port_b.addr = ring_fwd(pos_q, ring_addr_t'(OfsA));
            state_d     = StRd1;
          end
        end
      end
      StRd1: begin
        v0_d        = rdata_a;
        va_d        = rdata_b;
        port_a.en   = 1'b1;
        port_a.addr = ring_fwd(pos_q, ring_addr_t'(OfsB));
        port_b.en   = 1'b1;
        port_b.addr = ring_fwd(pos_q, ring_addr_t'(OfsC));
        state_d     = StRd2;
      end
      StRd2: begin
        vb_d        = rdata_a;
        vc_d        = rdata_b;
        port_a.en   = 1'b1;
        port_a.addr = back1;
        port_b.en   = 1'b1;
        port_b.addr = back2;
        state_d     = StWr;
      end
      StWr: begin
        // Hold until the output register can take the word
        if (out_free) begin
          port_a.en    = 1'b1;
          port_a.we    = 1'b1;
          port_a.addr  = pos_q;
          port_a.wdata = mix_res.store_word;
          port_b.en    = 1'b1;
          port_b.we    = 1'b1;
          port_b.addr  = back1;
          port_b.wdata = mix_res.new_word;
          pos_d        = back1;
          m_valid_d    = 1'b1;
          m_data_d     = mix_res.out_word;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state, position, configuration and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pos_q     <= '0;
      temper_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      temper_q  <= temper_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      v0_q      <= v0_d;
      va_q      <= va_d;
      vb_q      <= vb_d;
      vc_q      <= vc_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
